### rtl/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants of the CPU load meter
// Register indexes, reset values, scale constants and the control struct
// that steers the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package clm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLOW_WEIGHT     = 2'd0;
  localparam logic [1:0] CFG_FAST_WEIGHT     = 2'd1;
  localparam logic [1:0] CFG_REPORT_INTERVAL = 2'd2;

  localparam int WEIGHT_W   = 17;
  localparam int INTERVAL_W = 8;
  localparam int LEVEL_W    = 8;
  localparam int TENTHS_W   = 10;

  // Register reset values (weights are Q1.16 literals)
  localparam logic [WEIGHT_W-1:0]   SLOW_WEIGHT_RST     = 17'd3277;
  localparam logic [WEIGHT_W-1:0]   FAST_WEIGHT_RST     = 17'd13107;
  localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RST = 8'd10;

  // Scale factors fed to the multiplier
  localparam logic [9:0] COLOR_SCALE  = 10'd510;
  localparam logic [9:0] TENTHS_SCALE = 10'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;     // perform an operation this cycle
    logic accum;  // add product to accumulator (else load product)
  } mac_ctl_t;

endpackage

### rtl/clm_mac.sv
// ----------------------------------------------------------------------------
// clm_mac: shared multiply-accumulate unit
// One multiplier with a registered accumulator; every product is registered
// before it is used again.
// ----------------------------------------------------------------------------
module clm_mac #(
  parameter int OPW = 17
) (
  input  logic                  clk,
  input  clm_pkg::mac_ctl_t     ctl,
  input  logic [OPW-1:0]        op_a,
  input  logic [OPW-1:0]        op_b,
  output logic [2*OPW-1:0]      acc
);

  logic [2*OPW-1:0] acc_r;
  logic [2*OPW-1:0] prod;

  assign prod = op_a * op_b;
  assign acc  = acc_r;

  // Load or accumulate the product
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= ctl.accum ? acc_r + prod : prod;
    end
  end

endmodule

### rtl/clm_div.sv
// ----------------------------------------------------------------------------
// clm_div: iterative fractional divider
// Restoring division, one quotient bit per cycle: floor(num * 2^FB / den)
// for num < den.
// ----------------------------------------------------------------------------
module clm_div #(
  parameter int CW = 64,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] num,
  input  logic [CW-1:0] den,
  output logic          done,
  output logic [FB-1:0] quot
);

  localparam int CNTW = $clog2(FB);
  localparam logic [CNTW-1:0] LAST_STEP = CNTW'(FB - 1);

  logic            run_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [CW-1:0]   rem_r;
  logic [FB-1:0]   q_r;
  logic [CW:0]     sh;
  logic            ge;

  // Shift-compare-subtract step
  assign sh = {rem_r, 1'b0};
  assign ge = (sh >= {1'b0, den});

  assign done = done_r;
  assign quot = q_r;

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? CW'(sh - {1'b0, den}) : sh[CW-1:0];
      q_r   <= {q_r[FB-2:0], ge};
    end
  end

endmodule

### rtl/cpu_load_meter_ema_color_top.sv
// ----------------------------------------------------------------------------
// cpu_load_meter_ema_color_top: CPU load meter with EMA and red/green color
// Takes cumulative user/nice/system/idle tick counters, derives load, keeps
// a slow and a fast exponential average and reports a color per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries four cumulative tick counters.
//   The first transfer after reset only stores the counters; every later
//   transfer yields one result on the output channel (out_valid/out_ready):
//   red/green levels from the fast average, and on every report_interval-th
//   result the slow load in tenths of a percent with out_report_valid set.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; write them only while the block is idle.
//   Each item passes the delta step over the four counters, the check step,
//   the divider when the divide is needed, the multiply-accumulate phases and
//   the output step. One item is in flight at a time; in_ready is high only
//   in idle, so the next item is taken only once the last has been through
//   the bit-serial divider and the single shared multiplier.
//   A finished result waits in the output register while the next item is
//   taken; if the receiver still stalls when the next result is ready, the
//   sequencer holds until the output register frees.
//   Synchronous reset clears the averages, the report counter, the primed
//   flag and restores the default register values.
// ----------------------------------------------------------------------------
module cpu_load_meter_ema_color_top #(
  parameter int COUNTER_WIDTH = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_user_ticks,
  input  logic [63:0] in_nice_ticks,
  input  logic [63:0] in_system_ticks,
  input  logic [63:0] in_idle_ticks,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [9:0]  out_slow_load_tenths,
  output logic        out_report_valid,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int AVGW = FB + 1;
  localparam int OPW  = (FB + 1 > 10) ? FB + 1 : 10;
  localparam int ACCW = 2 * OPW;

  localparam logic [OPW-1:0]  ONE_OP   = OPW'(1) << FB;
  localparam logic [AVGW-1:0] ONE_AVG  = AVGW'(1) << FB;
  localparam logic [AVGW-1:0] HALF_AVG = AVGW'(1) << (FB - 1);
  localparam logic [ACCW-1:0] HALF_ACC = ACCW'(1) << (FB - 1);
  localparam logic [31:0]     ONE_32   = 32'd1 << FB;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MAC   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Multiply-accumulate phases
  localparam logic [2:0] PH_SLOW_NEW  = 3'd0;
  localparam logic [2:0] PH_SLOW_OLD  = 3'd1;
  localparam logic [2:0] PH_FAST_NEW  = 3'd2;
  localparam logic [2:0] PH_FAST_OLD  = 3'd3;
  localparam logic [2:0] PH_FAST_SAVE = 3'd4;
  localparam logic [2:0] PH_COLOR     = 3'd5;
  localparam logic [2:0] PH_TENTHS    = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ph_r;
  logic [1:0]  k_r;
  logic        primed_r;

  logic [16:0] slow_weight_r;
  logic [16:0] fast_weight_r;
  logic [7:0]  report_interval_r;
  logic [7:0]  count_r, count_nxt;

  logic [CW-1:0]   cur_r  [4];
  logic [CW-1:0]   prev_r [4];
  logic [CW-1:0]   busy_r, total_r;
  logic [CW-1:0]   delta;
  logic [AVGW-1:0] load_r;
  logic [AVGW-1:0] slow_r, fast_r;
  logic [7:0]      red_r, green_r;

  logic [7:0]  out_red_r, out_green_r;
  logic [9:0]  out_tenths_r;
  logic        out_report_r;
  logic        out_valid_r;

  logic            in_fire;
  logic            out_free;
  logic            div_start, div_done;
  logic [FB-1:0]   div_quot;
  logic            need_div;

  clm_pkg::mac_ctl_t mac_ctl;
  logic [OPW-1:0]    mac_a, mac_b;
  logic [ACCW-1:0]   mac_acc;
  logic [ACCW-1:0]   acc_round;
  logic [ACCW-FB-1:0] acc_shift;
  logic [7:0]        level;

  logic [OPW-1:0]  ws_op, wf_op, load_op, slow_op, fast_op;
  logic            fast_low;
  logic [8:0]      count_inc;
  logic [7:0]      interval;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Effective weights (clamped to one), operands in multiplier width
  assign ws_op   = ({15'b0, slow_weight_r} > ONE_32) ? ONE_OP : OPW'(slow_weight_r);
  assign wf_op   = ({15'b0, fast_weight_r} > ONE_32) ? ONE_OP : OPW'(fast_weight_r);
  assign load_op = OPW'(load_r);
  assign slow_op = OPW'(slow_r);
  assign fast_op = OPW'(fast_r);
  assign fast_low = (fast_r < HALF_AVG);

  // Rounded and truncated views of the accumulator
  assign acc_round = mac_acc + HALF_ACC;
  assign acc_shift = mac_acc[ACCW-1:FB];
  assign level     = (|acc_shift[ACCW-FB-1:8]) ? clm_pkg::LEVEL_MAX : acc_shift[7:0];

  // Delta of the selected counter, wrapping
  assign delta = cur_r[k_r] - prev_r[k_r];

  assign need_div  = (total_r != '0) && (busy_r < total_r);
  assign div_start = (state_r == S_CHECK) && need_div;

  // Report counter advance
  assign interval  = (report_interval_r == '0) ? 8'd1 : report_interval_r;
  assign count_inc = {1'b0, count_r} + 9'd1;
  assign count_nxt = (count_inc >= {1'b0, interval}) ? '0 : count_inc[7:0];

  // MAC operand selection per phase
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    if (state_r == S_MAC) begin
      case (ph_r)
        PH_SLOW_NEW: begin
          mac_ctl = '{en: 1'b1, accum: 1'b0};
          mac_a   = load_op;
          mac_b   = ws_op;
        end
        PH_SLOW_OLD: begin
          mac_ctl = '{en: 1'b1, accum: 1'b1};
          mac_a   = ONE_OP - ws_op;
          mac_b   = slow_op;
        end
        PH_FAST_NEW: begin
          mac_ctl = '{en: 1'b1, accum: 1'b0};
          mac_a   = load_op;
          mac_b   = wf_op;
        end
        PH_FAST_OLD: begin
          mac_ctl = '{en: 1'b1, accum: 1'b1};
          mac_a   = ONE_OP - wf_op;
          mac_b   = fast_op;
        end
        PH_COLOR: begin
          mac_ctl = '{en: 1'b1, accum: 1'b0};
          mac_a   = OPW'(clm_pkg::COLOR_SCALE);
          mac_b   = fast_low ? fast_op : ONE_OP - fast_op;
        end
        PH_TENTHS: begin
          mac_ctl = '{en: 1'b1, accum: 1'b0};
          mac_a   = OPW'(clm_pkg::TENTHS_SCALE);
          mac_b   = slow_op;
        end
        default: begin
          mac_ctl = '0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && primed_r) state_nxt = S_DELTA;
      S_DELTA: if (k_r == 2'd3) state_nxt = S_CHECK;
      S_CHECK: state_nxt = need_div ? S_DIV : S_MAC;
      S_DIV:   if (div_done) state_nxt = S_MAC;
      S_MAC:   if (ph_r == PH_TENTHS) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      ph_r              <= PH_SLOW_NEW;
      k_r               <= '0;
      primed_r          <= 1'b0;
      slow_r            <= '0;
      fast_r            <= '0;
      count_r           <= '0;
      out_valid_r       <= 1'b0;
      slow_weight_r     <= clm_pkg::SLOW_WEIGHT_RST;
      fast_weight_r     <= clm_pkg::FAST_WEIGHT_RST;
      report_interval_r <= clm_pkg::REPORT_INTERVAL_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          clm_pkg::CFG_SLOW_WEIGHT:     slow_weight_r     <= cfg_data;
          clm_pkg::CFG_FAST_WEIGHT:     fast_weight_r     <= cfg_data;
          clm_pkg::CFG_REPORT_INTERVAL: report_interval_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        primed_r <= 1'b1;
        k_r      <= '0;
      end
      if (state_r == S_DELTA) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == S_CHECK) begin
        ph_r <= PH_SLOW_NEW;
      end
      if (state_r == S_MAC) begin
        ph_r <= ph_r + 1'b1;
        if (ph_r == PH_FAST_NEW) slow_r <= acc_round[FB +: AVGW];
        if (ph_r == PH_FAST_SAVE) fast_r <= acc_round[FB +: AVGW];
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_r[0] <= in_user_ticks[CW-1:0];
      cur_r[1] <= in_nice_ticks[CW-1:0];
      cur_r[2] <= in_system_ticks[CW-1:0];
      cur_r[3] <= in_idle_ticks[CW-1:0];
      busy_r   <= '0;
      total_r  <= '0;
      if (!primed_r) begin
        prev_r[0] <= in_user_ticks[CW-1:0];
        prev_r[1] <= in_nice_ticks[CW-1:0];
        prev_r[2] <= in_system_ticks[CW-1:0];
        prev_r[3] <= in_idle_ticks[CW-1:0];
      end
    end
    // Accumulate deltas, one counter per cycle
    if (state_r == S_DELTA) begin
      total_r     <= total_r + delta;
      if (k_r != 2'd3) busy_r <= busy_r + delta;
      prev_r[k_r] <= cur_r[k_r];
    end
    // Load: zero total reads as 0, busy not below total saturates
    if (state_r == S_CHECK) begin
      load_r <= (total_r == '0) ? '0 : ONE_AVG;
    end
    if (state_r == S_DIV && div_done) begin
      load_r <= AVGW'(div_quot);
    end
    if (state_r == S_MAC && ph_r == PH_TENTHS) begin
      red_r   <= fast_low ? level : clm_pkg::LEVEL_MAX;
      green_r <= fast_low ? clm_pkg::LEVEL_MAX : level;
    end
    // Output register
    if (state_r == S_OUT && out_free) begin
      out_red_r    <= red_r;
      out_green_r  <= green_r;
      out_report_r <= (count_r == '0);
      out_tenths_r <= (count_r == '0) ? acc_round[FB +: 10] : '0;
    end
  end

  clm_div #(
    .CW (CW),
    .FB (FB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (busy_r),
    .den   (total_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  clm_mac #(
    .OPW (OPW)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  assign out_valid            = out_valid_r;
  assign out_red_level        = out_red_r;
  assign out_green_level      = out_green_r;
  assign out_slow_load_tenths = out_tenths_r;
  assign out_report_valid     = out_report_r;

`ifndef NO_ASSERTIONS
  // A new result only comes from the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside output step");

  // Averages stay within one
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slow_r <= ONE_AVG) && (fast_r <= ONE_AVG))
    else $error("average above one");

  // One color channel is always at full level
  a_color_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_level == 8'd255) || (out_green_level == 8'd255))
    else $error("neither color channel at full level");

  // No slow load value on a non-report result
  a_tenths_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_report_valid) |-> (out_slow_load_tenths == 10'd0))
    else $error("slow load shown without report");
`endif

endmodule
